// ===== src/bgmm_pkg.sv =====
`timescale 1ns / 1ps

package bgmm_pkg;

   localparam int ADC_W     = 12;
   localparam int MV_W      = 16;
   localparam int PCT_W     = 7;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam int DIV_N_W   = 22;
   localparam int DIV_D_W   = 16;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   // mv = 805 * (avg * 10) / 1000 = 161 * avg / 20, as a reciprocal product scaled by 2^17
   localparam int                    MV_RECIP_W = 21;
   localparam logic [MV_RECIP_W-1:0] MV_RECIP   = MV_RECIP_W'(1055130);
   localparam int                    MV_SHIFT   = 17;
   localparam logic [6:0]         PCT_SCALE   = 7'd100;
   localparam logic [PCT_W-1:0]   PCT_FULL    = PCT_W'(100);

   localparam logic [CSR_W-1:0]   LOG_DELTA_RESET = CSR_W'(100);
   localparam logic [CSR_W-1:0]   MIN_SPAN_RESET  = CSR_W'(2500);

   localparam logic [CSR_IDX_W-1:0] CSR_LOG_DELTA = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPAN  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG,
      ST_MV,
      ST_UPD,
      ST_PCT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== src/battery_gauge_min_max_percent.sv =====
`timescale 1ns / 1ps

// a request that does not close a batch only adds its sample to the sum; the sequencer stays idle
// a batch-closing request holds the request side through the average and
// millivolt steps by reciprocal product, the 22-step divider for the percent
// and the output step; its result is registered in the output step
// the output step waits while an earlier result is still stalled
// synchronous active-high reset clears the batch and the learned range and restores the csr values to their defaults

module battery_gauge_min_max_percent #(
   parameter int SAMPLES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bgmm_pkg::ADC_W-1:0]     req_adc_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bgmm_pkg::MV_W-1:0]      rsp_millivolts,
   output logic [bgmm_pkg::PCT_W-1:0]     rsp_charge_percent,
   output logic [bgmm_pkg::MV_W-1:0]      rsp_lowest_mv,
   output logic [bgmm_pkg::MV_W-1:0]      rsp_highest_mv,
   output logic                           rsp_log_event,
   input  logic                           csr_we,
   input  logic [bgmm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bgmm_pkg::CSR_W-1:0]     csr_wdata
);
   import bgmm_pkg::*;

   localparam int     CNT_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int     SUM_W     = ADC_W + CNT_W;
   localparam int     PROD_W    = 2 * SUM_W + 1;
   localparam int     AVG_SHIFT = SUM_W + $clog2(SAMPLES);
   localparam longint AVG_RECIP = ((longint'(1) << AVG_SHIFT) + SAMPLES - 1) / SAMPLES;
   localparam int     MVP_W     = ADC_W + MV_RECIP_W;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  sum_next;
   logic [ADC_W-1:0]  avg_ff, avg_in;
   logic [MV_W-1:0]   mv_ff, mv_in;
   logic [MV_W-1:0]   low_ff, low_in;
   logic [MV_W-1:0]   high_ff, high_in;
   logic              seen_ff, seen_in;
   logic [MV_W-1:0]   last_ff, last_in;
   logic              log_ff, log_in;
   logic              small_ff, small_in;
   logic [PCT_W-1:0]  pct_ff, pct_in;
   logic [CSR_W-1:0]  log_delta_ff, log_delta_in;
   logic [CSR_W-1:0]  min_span_ff, min_span_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [MV_W-1:0]   rsp_mv_ff, rsp_mv_in;
   logic [PCT_W-1:0]  rsp_pct_ff, rsp_pct_in;
   logic [MV_W-1:0]   rsp_low_ff, rsp_low_in;
   logic [MV_W-1:0]   rsp_high_ff, rsp_high_in;
   logic              rsp_log_ff, rsp_log_in;

   logic [MV_W-1:0]   low_new, high_new, span, delta;
   logic [PROD_W-1:0] avg_prod;
   logic [MVP_W-1:0]  mv_prod;
   logic              req_take, rsp_free;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   bgmm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_take = req_valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign sum_next = sum_ff + SUM_W'(req_adc_sample);
   assign avg_prod = PROD_W'(sum_ff) * PROD_W'(AVG_RECIP);
   assign mv_prod  = MVP_W'(avg_ff) * MVP_W'(MV_RECIP);

   always_comb begin
      low_new  = (!seen_ff || (mv_ff < low_ff)) ? mv_ff : low_ff;
      high_new = (!seen_ff || (mv_ff > high_ff)) ? mv_ff : high_ff;
      span     = high_new - low_new;
      delta    = (mv_ff >= last_ff) ? (mv_ff - last_ff) : (last_ff - mv_ff);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      mv_in        = mv_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      seen_in      = seen_ff;
      last_in      = last_ff;
      log_in       = log_ff;
      small_in     = small_ff;
      pct_in       = pct_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mv_in    = rsp_mv_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_log_in   = rsp_log_ff;
      div_req      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sum_in = sum_next;
               if (count_ff == CNT_W'(SAMPLES - 1)) begin
                  count_in = '0;
                  state_in = ST_AVG;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ST_AVG: begin
            avg_in   = avg_prod[AVG_SHIFT +: ADC_W];
            sum_in   = '0;
            state_in = ST_MV;
         end
         ST_MV: begin
            mv_in    = mv_prod[MV_SHIFT +: MV_W];
            state_in = ST_UPD;
         end
         ST_UPD: begin
            low_in           = low_new;
            high_in          = high_new;
            seen_in          = 1'b1;
            small_in         = span < min_span_ff;
            log_in           = delta > log_delta_ff;
            if (delta > log_delta_ff) begin
               last_in = mv_ff;
            end
            div_req.start    = 1'b1;
            div_req.dividend = DIV_N_W'(mv_ff - low_new) * DIV_N_W'(PCT_SCALE);
            div_req.divisor  = DIV_D_W'(span) + DIV_D_W'(1);
            state_in         = ST_PCT;
         end
         ST_PCT: begin
            if (div_rsp.done) begin
               pct_in   = small_ff ? PCT_FULL : div_rsp.quotient[PCT_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_mv_in    = mv_ff;
               rsp_pct_in   = pct_ff;
               rsp_low_in   = low_ff;
               rsp_high_in  = high_ff;
               rsp_log_in   = log_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      log_delta_in = log_delta_ff;
      min_span_in  = min_span_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LOG_DELTA: log_delta_in = csr_wdata;
            CSR_MIN_SPAN:  min_span_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         seen_ff      <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         log_delta_ff <= LOG_DELTA_RESET;
         min_span_ff  <= MIN_SPAN_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         log_delta_ff <= log_delta_in;
         min_span_ff  <= min_span_in;
      end
      avg_ff      <= avg_in;
      mv_ff       <= mv_in;
      low_ff      <= low_in;
      high_ff     <= high_in;
      log_ff      <= log_in;
      small_ff    <= small_in;
      pct_ff      <= pct_in;
      rsp_mv_ff   <= rsp_mv_in;
      rsp_pct_ff  <= rsp_pct_in;
      rsp_low_ff  <= rsp_low_in;
      rsp_high_ff <= rsp_high_in;
      rsp_log_ff  <= rsp_log_in;
   end

   assign req_stall          = !(state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_millivolts     = rsp_mv_ff;
   assign rsp_charge_percent = rsp_pct_ff;
   assign rsp_lowest_mv      = rsp_low_ff;
   assign rsp_highest_mv     = rsp_high_ff;
   assign rsp_log_event      = rsp_log_ff;

`ifndef SYNTHESIS
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_low_ff <= rsp_high_ff) && (rsp_low_ff <= rsp_mv_ff)
                       && (rsp_mv_ff <= rsp_high_ff))
      else $error("result range out of order");

   a_pct_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pct_ff <= PCT_FULL))
      else $error("percent above full");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_PCT))
      else $error("divider finished outside a wait step");

   a_open_batch: assert property (@(posedge clock) disable iff (reset)
      req_take && (count_ff != CNT_W'(SAMPLES - 1)) |=> (state_ff == ST_IDLE))
      else $error("sequencer left idle on an open batch");
`endif

endmodule

// ===== src/bgmm_div.sv =====
`timescale 1ns / 1ps

module bgmm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bgmm_pkg::div_req_type div_req,
   output bgmm_pkg::div_rsp_type div_rsp
);
   import bgmm_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   den_ff, den_in;
   logic [DIV_D_W:0]     trial;
   logic [DIV_D_W:0]     diff;
   logic                 fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_N_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_N_W-2:0], fits};
         rem_in = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
